// ===== hw/rtl/lgr_pkg.sv =====
// lgr_pkg: shared types and constants for the linear gain ramp block.
// Used by every module under hw/rtl; depends on nothing.

package lgr_pkg;

    localparam int MAX_FRAMES_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 24;
    localparam int FRAC_BITS       = 20;
    localparam int TARGET_W        = 24;
    localparam int COUNT_W         = 7;
    localparam int REM_W           = 24;
    localparam int DIVISOR_W       = 23;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 23;
    localparam int S_DATA_W        = ((TARGET_W + COUNT_W + 7) / 8) * 8;
    localparam int PROD_W          = 48;

    localparam logic [REM_W-1:0] REM_MAX = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SLOPE_SEL       = 3'd0,
        REG_RATE_STEP       = 3'd1,
        REG_FRAMES_PER_UNIT = 3'd2,
        REG_DURATION        = 3'd3,
        REG_MIN_STEP        = 3'd4,
        REG_GAIN_SCALE      = 3'd5
    } lgr_reg_t;

    typedef enum logic {
        OP_SET_TARGET = 1'b0,
        OP_GET_RAMP   = 1'b1
    } lgr_op_t;

    typedef enum logic {
        MODE_RATE     = 1'b0,
        MODE_DURATION = 1'b1
    } lgr_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIFF,
        ST_PLAN,
        ST_RATE,
        ST_DIV_DUR,
        ST_DIV_MIN,
        ST_EMIT
    } lgr_state_t;

    typedef struct packed {
        logic        slope_sel;
        logic [22:0] rate_step;
        logic [15:0] frames_per_unit;
        logic [15:0] duration_frames;
        logic [22:0] min_step;
        logic [22:0] gain_scale;
    } lgr_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lgr_div_stat_t;

endpackage

// ===== hw/rtl/lgr_cfg.sv =====
// lgr_cfg: configuration register file of the linear gain ramp.
// Depends on lgr_pkg for the register indexes and the config struct.

module lgr_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lgr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lgr_pkg::lgr_cfg_t                cfg
);

    lgr_pkg::lgr_cfg_t cfg_reg;
    lgr_pkg::lgr_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lgr_pkg::REG_SLOPE_SEL:       cfg_next.slope_sel       = cfg_data[0];
                lgr_pkg::REG_RATE_STEP:       cfg_next.rate_step       = cfg_data[22:0];
                lgr_pkg::REG_FRAMES_PER_UNIT: cfg_next.frames_per_unit = cfg_data[15:0];
                lgr_pkg::REG_DURATION:        cfg_next.duration_frames = cfg_data[15:0];
                lgr_pkg::REG_MIN_STEP:        cfg_next.min_step        = cfg_data[22:0];
                lgr_pkg::REG_GAIN_SCALE:      cfg_next.gain_scale      = cfg_data[22:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slope_sel       <= 1'b1;
            cfg_reg.rate_step       <= 23'd1049;
            cfg_reg.frames_per_unit <= 16'd1000;
            cfg_reg.duration_frames <= 16'd480;
            cfg_reg.min_step        <= 23'd105;
            cfg_reg.gain_scale      <= 23'd1048576;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/lgr_div.sv =====
// lgr_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on lgr_pkg for the divisor width and the status struct.

module lgr_div #(
    parameter int DIVIDEND_W = lgr_pkg::VALUE_WIDTH_DEF + 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [DIVIDEND_W-1:0]          dividend,
    input  logic [lgr_pkg::DIVISOR_W-1:0]  divisor,
    output lgr_pkg::lgr_div_stat_t         stat,
    output logic [DIVIDEND_W-1:0]          quotient
);

    localparam int DW    = lgr_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DW:0]   shifted;
    logic [DW+1:0] trial;
    logic          fits;

    assign shifted = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !trial[DW+1];

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? trial[DW-1:0] : shifted[DW-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

// ===== hw/rtl/linear_gain_ramp.sv =====
// Linear gain ramp generator. A set-target transfer (s_tuser 0) scales the target by
// gain_scale and plans a ramp through the MUL, SCALE, DIFF and PLAN states, then RATE in
// constant-rate mode, DIV_DUR in constant-duration mode and also DIV_MIN when the
// minimum-step clamp applies, both using the one-bit-per-cycle shared divider.
// A get-ramp transfer (s_tuser 1) returns min(frame_count, MAX_FRAMES, remaining)
// frame values at one per cycle, unless the output stalls, through a single output
// register, then the block is ready again; a finished ramp or a zero request returns one
// empty result (m_tuser 0). The input is not ready while an item is being worked on.
// Configuration writes are taken at any time and must only be issued while the block is
// idle. Depends on lgr_pkg, lgr_cfg and lgr_div.

module linear_gain_ramp #(
    parameter int MAX_FRAMES  = lgr_pkg::MAX_FRAMES_DEF,
    parameter int VALUE_WIDTH = lgr_pkg::VALUE_WIDTH_DEF,
    localparam int M_DATA_W   = ((VALUE_WIDTH + lgr_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // target_value [23:0], frame_count [30:24]
    input  logic [lgr_pkg::S_DATA_W-1:0]     s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gain_value [VALUE_WIDTH-1:0], frames_done [VALUE_WIDTH+6:VALUE_WIDTH]
    output logic [M_DATA_W-1:0]              m_tdata,
    // has_value
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lgr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int VW     = VALUE_WIDTH;
    localparam int WIDE   = VALUE_WIDTH + 16;
    localparam int CW     = lgr_pkg::COUNT_W;
    localparam int RATE_W = VALUE_WIDTH + 17;
    localparam int PW     = lgr_pkg::PROD_W;
    localparam int FB     = lgr_pkg::FRAC_BITS;
    localparam logic signed [WIDE-1:0] VAL_MAX =
        {{(WIDE - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [WIDE-1:0] VAL_MIN =
        {{(WIDE - VW + 1){1'b1}}, {(VW - 1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (FB - 1);

    function automatic logic [VW-1:0] sat_val(input logic signed [WIDE-1:0] v);
        logic [VW-1:0] r;
        if (v > VAL_MAX) begin
            r = VAL_MAX[VW-1:0];
        end else if (v < VAL_MIN) begin
            r = VAL_MIN[VW-1:0];
        end else begin
            r = v[VW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WIDE-1:0] sext(input logic [VW-1:0] v);
        return $signed({{(WIDE - VW){v[VW-1]}}, v});
    endfunction

    lgr_pkg::lgr_cfg_t      cfg;
    lgr_pkg::lgr_div_stat_t div_stat;
    logic                   div_start;
    logic [lgr_pkg::DIVISOR_W-1:0] div_divisor;
    logic [VW:0]            div_quot;

    lgr_cfg u_lgr_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lgr_pkg::lgr_state_t state_reg, state_next;

    logic                          started_reg, started_next;
    logic [VW-1:0]                 goal_reg, goal_next;
    logic [VW-1:0]                 level_reg, level_next;
    logic [VW-1:0]                 step_reg, step_next;
    logic [lgr_pkg::REM_W-1:0]     remaining_reg, remaining_next;
    logic [lgr_pkg::TARGET_W-1:0]  target_reg, target_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic                          neg_reg, neg_next;
    logic [VW:0]                   mag_reg, mag_next;
    logic [RATE_W-1:0]             rate_prod_reg, rate_prod_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CW-1:0]                 k_reg, k_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [VW-1:0]                 out_value_reg, out_value_next;
    logic [CW-1:0]                 out_done_reg, out_done_next;
    logic                          out_has_reg, out_has_next;
    logic                          out_last_reg, out_last_next;

    logic [CW-1:0]                 want;
    logic [CW-1:0]                 n_calc;
    logic signed [PW-1:0]          rounded;
    logic signed [PW-1:0]          scaled_full;
    logic [VW-1:0]                 scaled;
    logic signed [VW:0]            diff;
    logic [RATE_W-1:0]             rate_rem;
    logic [WIDE-1:0]               quot_w;
    logic signed [WIDE-1:0]        quot_s;
    logic signed [WIDE-1:0]        min_s;
    logic signed [WIDE-1:0]        rate_s;
    logic [lgr_pkg::DIVISOR_W-1:0] dur_eff;
    logic                          out_free;
    logic                          is_last;

    assign want = (s_tdata[30:24] > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : s_tdata[30:24];
    assign n_calc = (lgr_pkg::REM_W'(want) > remaining_reg) ? remaining_reg[CW-1:0] : want;

    assign rounded     = prod_reg + ROUND_HALF;
    assign scaled_full = rounded >>> FB;
    assign scaled      = sat_val($signed(scaled_full[WIDE-1:0]));

    assign diff     = $signed({goal_reg[VW-1], goal_reg}) - $signed({level_reg[VW-1], level_reg});
    assign rate_rem = rate_prod_reg >> FB;
    assign quot_w   = WIDE'(div_quot);
    assign quot_s   = $signed(quot_w);
    assign min_s    = $signed(WIDE'(cfg.min_step));
    assign rate_s   = $signed(WIDE'(cfg.rate_step));
    assign dur_eff  = (cfg.duration_frames == '0) ? lgr_pkg::DIVISOR_W'(1)
                                                  : lgr_pkg::DIVISOR_W'(cfg.duration_frames);

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (k_reg == n_reg - CW'(1));
    assign s_tready = (state_reg == lgr_pkg::ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        started_next   = started_reg;
        goal_next      = goal_reg;
        level_next     = level_reg;
        step_next      = step_reg;
        remaining_next = remaining_reg;
        target_next    = target_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        rate_prod_next = rate_prod_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_done_next  = out_done_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;
        div_divisor    = cfg.min_step;

        unique case (state_reg)
            lgr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == lgr_pkg::OP_GET_RAMP) begin
                        n_next     = n_calc;
                        k_next     = '0;
                        state_next = lgr_pkg::ST_EMIT;
                    end else begin
                        target_next = s_tdata[lgr_pkg::TARGET_W-1:0];
                        state_next  = lgr_pkg::ST_MUL;
                    end
                end
            end
            lgr_pkg::ST_MUL: begin
                prod_next  = $signed(target_reg) * $signed({1'b0, cfg.gain_scale});
                state_next = lgr_pkg::ST_SCALE;
            end
            lgr_pkg::ST_SCALE: begin
                goal_next = scaled;
                // first target after reset: jump straight there
                if (!started_reg) begin
                    level_next   = scaled;
                    started_next = 1'b1;
                end
                state_next = lgr_pkg::ST_DIFF;
            end
            lgr_pkg::ST_DIFF: begin
                neg_next   = diff[VW];
                mag_next   = diff[VW] ? (VW + 1)'(-diff) : diff;
                state_next = lgr_pkg::ST_PLAN;
            end
            lgr_pkg::ST_PLAN: begin
                if (cfg.slope_sel == lgr_pkg::MODE_RATE) begin
                    step_next      = sat_val((!neg_reg && mag_reg != '0) ? rate_s : -rate_s);
                    rate_prod_next = mag_reg * cfg.frames_per_unit;
                    state_next     = lgr_pkg::ST_RATE;
                end else begin
                    div_start   = 1'b1;
                    div_divisor = dur_eff;
                    state_next  = lgr_pkg::ST_DIV_DUR;
                end
            end
            lgr_pkg::ST_RATE: begin
                remaining_next = (rate_rem > RATE_W'(lgr_pkg::REM_MAX))
                               ? lgr_pkg::REM_MAX : rate_rem[lgr_pkg::REM_W-1:0];
                state_next     = lgr_pkg::ST_IDLE;
            end
            lgr_pkg::ST_DIV_DUR: begin
                if (div_stat.done) begin
                    if (cfg.min_step != '0 && quot_s < min_s) begin
                        // step too small: clamp to the minimum, negative when zero
                        step_next  = sat_val((!neg_reg && div_quot != '0) ? min_s : -min_s);
                        div_start  = 1'b1;
                        state_next = lgr_pkg::ST_DIV_MIN;
                    end else begin
                        step_next      = sat_val(neg_reg ? -quot_s : quot_s);
                        remaining_next = lgr_pkg::REM_W'(dur_eff);
                        state_next     = lgr_pkg::ST_IDLE;
                    end
                end
            end
            lgr_pkg::ST_DIV_MIN: begin
                if (div_stat.done) begin
                    remaining_next = (quot_w > WIDE'(lgr_pkg::REM_MAX))
                                   ? lgr_pkg::REM_MAX : quot_w[lgr_pkg::REM_W-1:0];
                    state_next     = lgr_pkg::ST_IDLE;
                end
            end
            lgr_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (n_reg == '0) begin
                        out_value_next = '0;
                        out_done_next  = '0;
                        out_has_next   = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = lgr_pkg::ST_IDLE;
                    end else begin
                        out_value_next = level_reg;
                        out_done_next  = n_reg;
                        out_has_next   = 1'b1;
                        out_last_next  = is_last;
                        level_next     = sat_val(sext(level_reg) + sext(step_reg));
                        k_next         = k_reg + CW'(1);
                        if (is_last) begin
                            remaining_next = remaining_reg - lgr_pkg::REM_W'(n_reg);
                            state_next     = lgr_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = lgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lgr_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            goal_reg      <= '0;
            level_reg     <= '0;
            step_reg      <= '0;
            remaining_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            goal_reg      <= goal_next;
            level_reg     <= level_next;
            step_reg      <= step_next;
            remaining_reg <= remaining_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg    <= target_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        rate_prod_reg <= rate_prod_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        out_value_reg <= out_value_next;
        out_done_reg  <= out_done_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    lgr_div #(
        .DIVIDEND_W (VW + 1)
    ) u_lgr_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({out_done_reg, out_value_reg});
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/lgr_checker.sv =====
// lgr_checker: port-level assertions for linear_gain_ramp, bound to the top level.
// Depends on lgr_pkg for the field widths.

module lgr_checker #(
    parameter int VALUE_WIDTH = lgr_pkg::VALUE_WIDTH_DEF,
    localparam int M_DATA_W   = ((VALUE_WIDTH + lgr_pkg::COUNT_W + 7) / 8) * 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    // an empty result is all zeros and closes the request
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
        else $error("empty result not zero or not last");

    // a frame value always reports a nonzero frame count
    a_frames_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[VALUE_WIDTH+lgr_pkg::COUNT_W-1:VALUE_WIDTH] != '0)
        else $error("frame value with zero frames_done");

    // a request transfer always yields at least one result, so input stalls
    a_request_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == lgr_pkg::OP_GET_RAMP |=> !s_tready)
        else $error("input ready right after a ramp request");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind linear_gain_ramp lgr_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_lgr_checker (.*);

// ===== verif/linear_gain_ramp_tb.sv =====
`timescale 1ns / 100ps

// linear_gain_ramp_tb: self-checking testbench for the linear gain ramp block.
// Drives target and ramp-request transfers under several register settings and idling
// patterns, checking every frame against a scoreboard; depends on lgr_pkg and linear_gain_ramp.

module linear_gain_ramp_tb;

    localparam int VW           = lgr_pkg::VALUE_WIDTH_DEF;
    localparam int MAXF         = lgr_pkg::MAX_FRAMES_DEF;
    localparam int CNT_W        = lgr_pkg::COUNT_W;
    localparam int TGT_W        = lgr_pkg::TARGET_W;
    localparam int IDX_W        = lgr_pkg::CFG_INDEX_W;
    localparam int DAT_W        = lgr_pkg::CFG_DATA_W;
    localparam int SD_W         = lgr_pkg::S_DATA_W;
    localparam int M_W          = ((VW + CNT_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint VAL_MAX   = (longint'(1) << (VW - 1)) - 1;
    localparam longint VAL_MIN   = -(longint'(1) << (VW - 1));
    localparam longint REM_LIMIT = (longint'(1) << lgr_pkg::REM_W) - 1;

    typedef struct packed {
        logic [VW-1:0]    gain_value;
        logic [CNT_W-1:0] frames_done;
        logic             has_value;
        logic             last;
    } frame_t;

    class ramp_scoreboard;
        lgr_pkg::lgr_cfg_t cfg;
        bit       started;
        longint   goal;
        longint   level;
        longint   step;
        longint   remaining;
        frame_t   pending_frames[$];
        int       errors;

        function new();
            cfg.slope_sel       = lgr_pkg::MODE_DURATION;
            cfg.rate_step       = 23'd1049;
            cfg.frames_per_unit = 16'd1000;
            cfg.duration_frames = 16'd480;
            cfg.min_step        = 23'd105;
            cfg.gain_scale      = 23'd1048576;
            started   = 1'b0;
            goal      = 0;
            level     = 0;
            step      = 0;
            remaining = 0;
            errors    = 0;
        endfunction

        function longint clip(longint v);
            if (v > VAL_MAX) return VAL_MAX;
            if (v < VAL_MIN) return VAL_MIN;
            return v;
        endfunction

        function int outstanding();
            return pending_frames.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
            case (idx)
                lgr_pkg::REG_SLOPE_SEL:       cfg.slope_sel = data[0];
                lgr_pkg::REG_RATE_STEP:       cfg.rate_step = data[22:0];
                lgr_pkg::REG_FRAMES_PER_UNIT: cfg.frames_per_unit = data[15:0];
                lgr_pkg::REG_DURATION:        cfg.duration_frames = data[15:0];
                lgr_pkg::REG_MIN_STEP:        cfg.min_step = data[22:0];
                lgr_pkg::REG_GAIN_SCALE:      cfg.gain_scale = data[22:0];
                default: ;
            endcase
        endfunction

        // scale the target, then plan step and frame count for the new ramp
        function void plan_ramp(logic [TGT_W-1:0] tgt);
            longint t, scaled, diff, mag, s, smag, dur, rem;
            t = longint'($signed(tgt));
            scaled = clip((t * longint'(cfg.gain_scale)
                           + (longint'(1) << (lgr_pkg::FRAC_BITS - 1))) >>> lgr_pkg::FRAC_BITS);
            if (!started) begin
                level = scaled;
                started = 1'b1;
            end
            goal = scaled;
            diff = goal - level;
            mag = (diff < 0) ? -diff : diff;
            if (cfg.slope_sel == lgr_pkg::MODE_RATE) begin
                step = clip((goal > level) ? longint'(cfg.rate_step) : -longint'(cfg.rate_step));
                rem = (mag * longint'(cfg.frames_per_unit)) >>> lgr_pkg::FRAC_BITS;
            end else begin
                dur = (cfg.duration_frames == 16'd0) ? longint'(1) : longint'(cfg.duration_frames);
                s = diff / dur;
                smag = (s < 0) ? -s : s;
                rem = dur;
                if (smag < longint'(cfg.min_step)) begin
                    // a zero step is pushed downward
                    s = (s > 0) ? longint'(cfg.min_step) : -longint'(cfg.min_step);
                    rem = mag / longint'(cfg.min_step);
                end
                step = clip(s);
            end
            remaining = (rem > REM_LIMIT) ? REM_LIMIT : rem;
        endfunction

        function void take_input(lgr_pkg::lgr_op_t op, logic [TGT_W-1:0] tgt,
                                 logic [CNT_W-1:0] fc);
            longint want, n;
            frame_t f;
            if (op == lgr_pkg::OP_SET_TARGET) begin
                plan_ramp(tgt);
                return;
            end
            want = longint'(fc);
            if (want > MAXF) want = MAXF;
            n = (remaining < want) ? remaining : want;
            if (n <= 0) begin
                f.gain_value  = '0;
                f.frames_done = '0;
                f.has_value   = 1'b0;
                f.last        = 1'b1;
                pending_frames.push_back(f);
                return;
            end
            for (longint k = 0; k < n; k++) begin
                f.gain_value  = level[VW-1:0];
                f.frames_done = n[CNT_W-1:0];
                f.has_value   = 1'b1;
                f.last        = (k == n - 1);
                pending_frames.push_back(f);
                level = clip(level + step);
            end
            remaining -= n;
        endfunction

        task check_frame(logic [VW-1:0] gv, logic [CNT_W-1:0] fd, logic hv, logic lst);
            frame_t f;
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected frame gain %h", gv));
                return;
            end
            f = pending_frames.pop_front();
            if (gv !== f.gain_value)
                report_mismatch($sformatf("gain_value %h, want %h", gv, f.gain_value));
            if (fd !== f.frames_done)
                report_mismatch($sformatf("frames_done %0d, want %0d", fd, f.frames_done));
            if (hv !== f.has_value)
                report_mismatch($sformatf("has_value %b, want %b", hv, f.has_value));
            if (lst !== f.last)
                report_mismatch($sformatf("last %b, want %b", lst, f.last));
        endtask
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [SD_W-1:0]    s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [M_W-1:0]     m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [DAT_W-1:0]   cfg_data  = '0;

    int cycles        = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    ramp_scoreboard sb;

    linear_gain_ramp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = aresetn && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_frame(m_tdata[VW-1:0], m_tdata[VW +: CNT_W], m_tuser, m_tlast);
    end

    function automatic logic [TGT_W-1:0] random_target();
        logic [31:0] r;
        longint      d;
        r = $urandom();
        // keep some targets near the current goal so the minimum-step clamp shows up
        if ($urandom_range(2) == 0) begin
            d = sb.goal + longint'($urandom_range(4000)) - 2000;
            return d[TGT_W-1:0];
        end
        return r[TGT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] request_len();
        logic [31:0] r;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60)      r = $urandom_range(64, 1);
        else if (pick < 75) r = MAXF;
        else if (pick < 85) r = 0;
        else                r = $urandom_range(127, 65);
        return r[CNT_W-1:0];
    endfunction

    task automatic send_item(lgr_pkg::lgr_op_t op, logic [TGT_W-1:0] tgt,
                             logic [CNT_W-1:0] fc);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(SD_W - TGT_W - CNT_W){1'b0}}, fc, tgt};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.take_input(op, tgt, fc);
    endtask

    // sender holds off until every frame is back, then lets the divider settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(lgr_pkg::lgr_mode_t mode, logic [22:0] rstep, logic [15:0] fpu,
                            logic [15:0] dur, logic [22:0] mstep, logic [22:0] scale);
        write_reg(lgr_pkg::REG_SLOPE_SEL, {22'd0, mode});
        write_reg(lgr_pkg::REG_RATE_STEP, rstep);
        write_reg(lgr_pkg::REG_FRAMES_PER_UNIT, {7'd0, fpu});
        write_reg(lgr_pkg::REG_DURATION, {7'd0, dur});
        write_reg(lgr_pkg::REG_MIN_STEP, mstep);
        write_reg(lgr_pkg::REG_GAIN_SCALE, scale);
    endtask

    // mostly a target followed by a few requests, the rest single random transfers
    task automatic run_random(int count);
        int          sent;
        int          reqs;
        logic [31:0] r;
        sent = 0;
        while (sent < count) begin
            r = $urandom();
            if ($urandom_range(99) < 70) begin
                send_item(lgr_pkg::OP_SET_TARGET, random_target(), r[30:24]);
                reqs = $urandom_range(4, 1);
                repeat (reqs) send_item(lgr_pkg::OP_GET_RAMP, random_target(), request_len());
                sent += reqs + 1;
            end else begin
                send_item(lgr_pkg::lgr_op_t'(r[31]), r[TGT_W-1:0], r[30:24]);
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] r1, r2, r3;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part with reset settings
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd5);
        send_item(lgr_pkg::OP_SET_TARGET, 24'h7FFFFF, 7'd0);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd64);
        send_item(lgr_pkg::OP_SET_TARGET, 24'h800000, 7'd127);
        send_item(lgr_pkg::OP_GET_RAMP, 24'hFFFFFF, 7'd127);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd0);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd64);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd1);
        send_item(lgr_pkg::OP_SET_TARGET, 24'h000000, 7'd0);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd64);
        send_item(lgr_pkg::OP_SET_TARGET, 24'h000100, 7'd0);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd64);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd64);
        send_item(lgr_pkg::OP_SET_TARGET, 24'hF00000, 7'd0);
        send_item(lgr_pkg::OP_GET_RAMP, 24'h000000, 7'd100);
        wait_idle();

        // constant rate, finest step, long ramps, scale at its top
        set_regs(lgr_pkg::MODE_RATE, 23'd1, 16'd65535, 16'd480, 23'd105, 23'h7FFFFF);
        run_random(14);
        wait_idle();

        // constant rate, coarse step overshoots and saturates
        send_idle_pct = 84;
        set_regs(lgr_pkg::MODE_RATE, 23'h7FFFFF, 16'd1, 16'd480, 23'd105, 23'd1048576);
        run_random(14);
        wait_idle();

        // zero duration and zero minimum step
        send_idle_pct = 0;
        stall_pct     = 84;
        set_regs(lgr_pkg::MODE_DURATION, 23'd1049, 16'd1000, 16'd0, 23'd0, 23'd1048576);
        run_random(14);
        wait_idle();

        send_idle_pct = 30;
        stall_pct     = 30;
        set_regs(lgr_pkg::MODE_DURATION, 23'd1049, 16'd1000, 16'd65535, 23'h7FFFFF,
                 23'd1572864);
        run_random(14);
        wait_idle();

        send_idle_pct = 0;
        stall_pct     = 0;
        r1 = $urandom_range(600, 1);
        r2 = $urandom_range(5000, 1);
        r3 = $urandom_range(23'd2097152, 23'd524288);
        set_regs(lgr_pkg::MODE_DURATION, 23'd1049, 16'd1000, r1[15:0], r2[22:0], r3[22:0]);
        write_reg(REG_UNUSED, 23'h7FFFFF);
        run_random(8);
        wait_idle();
        run_random(8);
        wait_idle();

        send_idle_pct = 30;
        stall_pct     = 30;
        set_regs(lgr_pkg::MODE_RATE, 23'd1049, 16'd1000, 16'd480, 23'd105, 23'd0);
        run_random(6);
        wait_idle();

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lgr_pkg.sv
hw/rtl/lgr_cfg.sv
hw/rtl/lgr_div.sv
hw/rtl/linear_gain_ramp.sv
hw/rtl/lgr_checker.sv
verif/linear_gain_ramp_tb.sv
